// File: sv/crt_solver_unit_assert.svh
// Assertion macros used by the checker file of crt_solver_unit.
// Needs clk and rst_n in the scope of each use.
`ifndef CRT_SOLVER_UNIT_ASSERT_SVH
`define CRT_SOLVER_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define CRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crt_solver_unit: assertion failed");

// next-cycle implication, off during reset
`define CRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crt_solver_unit: assertion failed");

// next-cycle implication, also checked while reset is applied
`define CRT_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("crt_solver_unit: assertion failed");

`endif

// File: sv/crt_pkg.sv
// Shared types and codes of the CRT solver.
// No dependencies.
package crt_pkg;
  localparam int CRT_MAX_CONG = 4;
  localparam int CRT_MOD_BITS = 16;
  localparam int CRT_IDX_W    = $clog2(CRT_MAX_CONG);

  typedef logic [1:0] status_t;
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_ZERO    = 2'd1;
  localparam status_t ST_COPRIME = 2'd2;
  localparam status_t ST_MANY    = 2'd3;

  typedef logic [1:0] div_len_t;
  localparam div_len_t DIV_LEN_16 = 2'd0;
  localparam div_len_t DIV_LEN_32 = 2'd1;
  localparam div_len_t DIV_LEN_64 = 2'd2;

  typedef struct packed {
    logic [CRT_MAX_CONG-1:0][15:0] res;
    logic [CRT_MAX_CONG-1:0][15:0] modv;
    logic [2:0]                    cnt;
    status_t                       err;
  } job_t;

  typedef struct packed {
    logic     start;
    div_len_t len;
  } div_ctl_t;
endpackage

// File: sv/crt_solver_unit.sv
// CRT solver top level: front end, job queue and solving back end.
// Depends on crt_pkg, crt_front, crt_jobq, crt_back.
//
// Input stream: one congruence per request, in_tdata = residue and modulus,
// in_tlast marks the final congruence of a system;
// in_tready drops only while the two-entry job queue is full.
// Output stream: one request per system, out_tdata = solution, out_tuser =
// status (0 ok, 1 zero modulus, 2 not coprime, 3 too many congruences).
// After the last congruence the back end forms the product of the moduli,
// then for each modulus above one runs two 64-bit serial divisions, one
// 16-bit division per extended Euclid step, a 16-bit and a 32-bit division
// and a bit-serial modular multiply; the single bit-serial divider does every division.
// Systems flagged with an error in the front end go straight to the output.
// The back end solves one system at a time; the front keeps loading the next.
// Reset (rst_n low, synchronous) empties the queue and clears partial systems.
// A stalled out_tready holds the result; loading continues until the queue fills.
module crt_solver_unit #(
  parameter int MAX_CONGRUENCES = crt_pkg::CRT_MAX_CONG,
  parameter int MODULUS_BITS    = crt_pkg::CRT_MOD_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] residue, [31:16] modulus
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] solution
  output logic [1:0]  out_tuser   // [1:0] status
);
  import crt_pkg::*;

  job_t push_job, pop_job;
  logic push, pop, q_full, q_empty;

  crt_front #(
    .MAX_CONGRUENCES (MAX_CONGRUENCES),
    .MODULUS_BITS    (MODULUS_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_res   (in_tdata[15:0]),
    .in_mod   (in_tdata[31:16]),
    .in_last  (in_tlast),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  crt_jobq u_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .pop_job  (pop_job)
  );

  crt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_job      (pop_job),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sol    (out_tdata),
    .out_status (out_tuser)
  );
endmodule

// File: sv/crt_front.sv
// Front end: accepts congruences, stores them and flags errors; pushes a job on last.
// Depends on crt_pkg.
module crt_front #(
  parameter int MAX_CONGRUENCES = crt_pkg::CRT_MAX_CONG,
  parameter int MODULUS_BITS    = crt_pkg::CRT_MOD_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [15:0]   in_res,
  input  logic [15:0]   in_mod,
  input  logic          in_last,
  output logic          push,
  output crt_pkg::job_t push_job,
  input  logic          q_full
);
  import crt_pkg::*;

  localparam logic [15:0] MASK = 16'((32'd1 << MODULUS_BITS) - 32'd1);

  job_t        job_r, job_nxt;
  logic [15:0] res_w, mod_w;
  logic        acc_w;

  assign res_w    = in_res & MASK;
  assign mod_w    = in_mod & MASK;
  assign in_ready = !q_full;
  assign acc_w    = in_valid && in_ready;
  assign push     = acc_w && in_last;
  assign push_job = job_nxt;

  always_comb begin
    job_nxt = job_r;
    if (mod_w == 16'd0) begin
      if (job_r.err == ST_OK) job_nxt.err = ST_ZERO;
    end else if (job_r.cnt >= 3'(MAX_CONGRUENCES)) begin
      if (job_r.err == ST_OK) job_nxt.err = ST_MANY;
    end else begin
      job_nxt.res[job_r.cnt[CRT_IDX_W-1:0]]  = res_w;
      job_nxt.modv[job_r.cnt[CRT_IDX_W-1:0]] = mod_w;
      job_nxt.cnt = job_r.cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r.cnt <= 3'd0;
      job_r.err <= ST_OK;
    end else if (acc_w) begin
      job_r.res  <= job_nxt.res;
      job_r.modv <= job_nxt.modv;
      if (in_last) begin
        job_r.cnt <= 3'd0;
        job_r.err <= ST_OK;
      end else begin
        job_r.cnt <= job_nxt.cnt;
        job_r.err <= job_nxt.err;
      end
    end
  end
endmodule

// File: sv/crt_jobq.sv
// Two-entry job queue between front and back.
// Depends on crt_pkg.
module crt_jobq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  crt_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output crt_pkg::job_t pop_job
);
  import crt_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign pop_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

// File: sv/crt_div.sv
// Bit-serial restoring divider: 64/32/16-bit dividend by 16-bit divisor.
// Depends on crt_pkg.
module crt_div (
  input  logic              clk,
  input  logic              rst_n,
  input  crt_pkg::div_ctl_t ctl,
  input  logic [63:0]       dividend,
  input  logic [15:0]       divisor,
  output logic              done,
  output logic [63:0]       quot,
  output logic [15:0]       rem
);
  import crt_pkg::*;

  logic [63:0] dvd_r;
  logic [15:0] rem_r, dsr_r;
  logic [6:0]  cnt_r;
  logic        busy_r, done_r;
  logic [16:0] trial;
  logic        fit;

  assign trial = {rem_r, dvd_r[63]};
  assign fit   = trial >= {1'b0, dsr_r};
  assign done  = done_r;
  assign quot  = dvd_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        unique case (ctl.len)
          DIV_LEN_16: cnt_r <= 7'd16;
          DIV_LEN_32: cnt_r <= 7'd32;
          default:    cnt_r <= 7'd64;
        endcase
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= 16'd0;
      dsr_r <= divisor;
      unique case (ctl.len)
        DIV_LEN_16: dvd_r <= dividend << 48;
        DIV_LEN_32: dvd_r <= dividend << 32;
        default:    dvd_r <= dividend;
      endcase
    end else if (busy_r) begin
      rem_r <= fit ? 16'(trial - {1'b0, dsr_r}) : trial[15:0];
      dvd_r <= {dvd_r[62:0], fit};
    end
  end
endmodule

// File: sv/crt_back.sv
// Back end: sequencer that solves one queued system with a shared divider.
// Depends on crt_pkg and crt_div.
module crt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  crt_pkg::job_t q_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [63:0]   out_sol,
  output logic [1:0]    out_status
);
  import crt_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0,  S_MLO   = 5'd1,  S_MHI   = 5'd2,
                         S_MADD  = 5'd3,  S_NEXT  = 5'd4,  S_DIVM  = 5'd5,
                         S_DIVV  = 5'd6,  S_EUCHK = 5'd7,  S_EUDIV = 5'd8,
                         S_EUMUL = 5'd9,  S_EUUPD = 5'd10, S_DIVA  = 5'd11,
                         S_AMUL  = 5'd12, S_DIVT  = 5'd13, S_MMDBL = 5'd14,
                         S_MMADD = 5'd15, S_ACC   = 5'd16, S_OUT   = 5'd17;

  logic [4:0]  state_r;
  job_t        job_r;
  logic [2:0]  idx_r;
  logic [63:0] m_r, part_r, x_r, acc_r, sol_r;
  logic [47:0] plo_r, phi_r;
  logic [15:0] r0_r, r1_r, r2_r, q_r, inv_r, a_r, t_r;
  logic signed [17:0] s0_r, s1_r, qs_r;
  logic [31:0] prod_r;
  logic [3:0]  bit_r;
  status_t     stat_r;
  logic        wait_r;

  logic [15:0] cur_mod, cur_res;
  div_ctl_t    dctl;
  logic [63:0] d_dvd, d_quot;
  logic [15:0] d_dsr, d_rem;
  logic        d_done, is_div;
  logic [64:0] dbl_w, add_w, acc_w;
  logic signed [34:0] qs_w;
  logic signed [17:0] inv_w;

  assign cur_mod = job_r.modv[idx_r[CRT_IDX_W-1:0]];
  assign cur_res = job_r.res[idx_r[CRT_IDX_W-1:0]];
  assign pop     = (state_r == S_IDLE) && !q_empty;

  assign out_valid  = state_r == S_OUT;
  assign out_sol    = sol_r;
  assign out_status = stat_r;

  assign dbl_w = {x_r, 1'b0};
  assign add_w = {1'b0, x_r} + {1'b0, part_r};
  assign acc_w = {1'b0, acc_r} + {1'b0, x_r};
  assign qs_w  = $signed({19'd0, q_r}) * s1_r;
  assign inv_w = (s0_r < 0) ? s0_r + $signed({2'b0, cur_mod}) : s0_r;

  always_comb begin
    is_div = 1'b1;
    d_dvd  = 64'd0;
    d_dsr  = cur_mod;
    dctl.len = DIV_LEN_64;
    unique case (state_r)
      S_DIVM:  d_dvd = m_r;
      S_DIVV:  d_dvd = part_r;
      S_EUDIV: begin
        d_dvd = {48'd0, r0_r};
        d_dsr = r1_r;
        dctl.len = DIV_LEN_16;
      end
      S_DIVA: begin
        d_dvd = {48'd0, cur_res};
        dctl.len = DIV_LEN_16;
      end
      S_DIVT: begin
        d_dvd = {32'd0, prod_r};
        dctl.len = DIV_LEN_32;
      end
      default: is_div = 1'b0;
    endcase
    dctl.start = is_div && !wait_r;
  end

  crt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (dctl),
    .dividend (d_dvd),
    .divisor  (d_dsr),
    .done     (d_done),
    .quot     (d_quot),
    .rem      (d_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wait_r  <= 1'b0;
    end else begin
      if (dctl.start) wait_r <= 1'b1;
      if (d_done) wait_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            job_r <= q_job;
            m_r   <= 64'd1;
            idx_r <= 3'd0;
            acc_r <= 64'd0;
            if (q_job.err != ST_OK) begin
              stat_r  <= q_job.err;
              sol_r   <= 64'd0;
              state_r <= S_OUT;
            end else begin
              state_r <= S_MLO;
            end
          end
        end
        S_MLO: begin
          plo_r   <= m_r[31:0] * cur_mod;
          state_r <= S_MHI;
        end
        S_MHI: begin
          phi_r   <= m_r[63:32] * cur_mod;
          state_r <= S_MADD;
        end
        S_MADD: begin
          m_r <= {phi_r[31:0], 32'd0} + {16'd0, plo_r};
          if (idx_r + 3'd1 == job_r.cnt) begin
            idx_r   <= 3'd0;
            state_r <= S_NEXT;
          end else begin
            idx_r   <= idx_r + 3'd1;
            state_r <= S_MLO;
          end
        end
        S_NEXT: begin
          if (idx_r == job_r.cnt) begin
            stat_r  <= ST_OK;
            sol_r   <= acc_r;
            state_r <= S_OUT;
          end else if (cur_mod < 16'd2) begin
            idx_r <= idx_r + 3'd1;
          end else begin
            state_r <= S_DIVM;
          end
        end
        S_DIVM: begin
          if (d_done) begin
            part_r  <= d_quot;
            state_r <= S_DIVV;
          end
        end
        S_DIVV: begin
          if (d_done) begin
            r0_r    <= cur_mod;
            r1_r    <= d_rem;
            s0_r    <= 18'sd0;
            s1_r    <= 18'sd1;
            state_r <= S_EUCHK;
          end
        end
        S_EUCHK: begin
          if (r1_r != 16'd0) begin
            state_r <= S_EUDIV;
          end else if (r0_r != 16'd1) begin
            stat_r  <= ST_COPRIME;
            sol_r   <= 64'd0;
            state_r <= S_OUT;
          end else begin
            inv_r   <= inv_w[15:0];
            state_r <= S_DIVA;
          end
        end
        S_EUDIV: begin
          if (d_done) begin
            q_r     <= d_quot[15:0];
            r2_r    <= d_rem;
            state_r <= S_EUMUL;
          end
        end
        S_EUMUL: begin
          qs_r    <= qs_w[17:0];
          state_r <= S_EUUPD;
        end
        S_EUUPD: begin
          r0_r    <= r1_r;
          r1_r    <= r2_r;
          s0_r    <= s1_r;
          s1_r    <= s0_r - qs_r;
          state_r <= S_EUCHK;
        end
        S_DIVA: begin
          if (d_done) begin
            a_r     <= d_rem;
            state_r <= S_AMUL;
          end
        end
        S_AMUL: begin
          prod_r  <= a_r * inv_r;
          state_r <= S_DIVT;
        end
        S_DIVT: begin
          if (d_done) begin
            t_r     <= d_rem;
            x_r     <= 64'd0;
            bit_r   <= 4'd15;
            state_r <= S_MMDBL;
          end
        end
        S_MMDBL: begin
          x_r     <= (dbl_w >= {1'b0, m_r}) ? 64'(dbl_w - {1'b0, m_r}) : dbl_w[63:0];
          state_r <= S_MMADD;
        end
        S_MMADD: begin
          if (t_r[bit_r]) begin
            x_r <= (add_w >= {1'b0, m_r}) ? 64'(add_w - {1'b0, m_r}) : add_w[63:0];
          end
          if (bit_r == 4'd0) begin
            state_r <= S_ACC;
          end else begin
            bit_r   <= bit_r - 4'd1;
            state_r <= S_MMDBL;
          end
        end
        S_ACC: begin
          acc_r   <= (acc_w >= {1'b0, m_r}) ? 64'(acc_w - {1'b0, m_r}) : acc_w[63:0];
          idx_r   <= idx_r + 3'd1;
          state_r <= S_NEXT;
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: sv/crt_solver_unit_chk.sv
// Port-level checker for crt_solver_unit, bound to the top level.
// Depends on crt_pkg and crt_solver_unit_assert.svh.
`include "crt_solver_unit_assert.svh"

module crt_solver_unit_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import crt_pkg::*;

  `CRT_ASSERT_RST(a_reset_idle, !rst_n, !out_tvalid)
  `CRT_ASSERT_IMP(a_err_zero_sol, out_tvalid && out_tuser != ST_OK, out_tdata == 64'd0)
  `CRT_ASSERT_NXT(a_one_per_sys, out_tvalid && out_tready, !out_tvalid)
  `CRT_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
endmodule

bind crt_solver_unit crt_solver_unit_chk u_chk (.*);

// File: tb/tb_crt_solver_unit.sv
// Self-checking testbench for crt_solver_unit: streams congruence systems in,
// predicts each solution and status, and checks every result request in order.
// Depends on crt_pkg and the crt_solver_unit RTL.
module tb_crt_solver_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import crt_pkg::*;

  localparam int LIMIT_CYCLES = 6000000;
  localparam int HOLD_CYCLES  = 4000;
  localparam int TAIL_CYCLES  = 3000;

  typedef struct {
    logic [63:0] sol;
    status_t     st;
  } crt_result_t;

  typedef struct {
    logic [15:0] r;
    logic [15:0] m;
    bit          l;
    bit          chk;
    logic [63:0] s;
    status_t     st;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  crt_solver_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [15:0]     p_res[CRT_MAX_CONG];
  logic [15:0]     p_mod[CRT_MAX_CONG];
  int              p_cnt = 0;
  longint unsigned p_prod = 1;
  status_t         p_err = ST_OK;

  crt_result_t pending_solutions[$];
  int  tx_idle = 0, rx_idle = 0, hold_cnt = 0;
  int  mismatches = 0, results_seen = 0, items_sent = 0, cycles = 0;
  bit  row_chk = 0;
  logic [63:0] row_sol = '0;
  status_t     row_st = ST_OK;

  function automatic bit mod_inverse(longint unsigned v, longint unsigned n,
                                     output longint unsigned inv);
    longint r0, r1, s0, s1, q, r2, s2;
    r0 = n; r1 = v; s0 = 0; s1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      r2 = r0 - q * r1;
      s2 = s0 - q * s1;
      r0 = r1; r1 = r2; s0 = s1; s1 = s2;
    end
    inv = 0;
    if (r0 != 1) return 0;
    if (s0 < 0) s0 += n;
    inv = s0;
    return 1;
  endfunction

  function automatic status_t solve_system(output longint unsigned sol);
    longint unsigned acc, mi, part, inv, t, room;
    acc = 0;
    sol = 0;
    for (int i = 0; i < p_cnt; i++) begin
      mi = p_mod[i];
      if (mi < 2) continue;
      part = p_prod / mi;
      if (!mod_inverse(part % mi, mi, inv)) return ST_COPRIME;
      t = (longint'(p_res[i]) % mi) * inv % mi;
      t = t * part;
      room = p_prod - t;
      acc = (acc >= room) ? acc - room : acc + t;
    end
    sol = acc;
    return ST_OK;
  endfunction

  // returns 1 with a result when the item closes a system
  function automatic bit predict_congruence(logic [15:0] r, logic [15:0] m, bit l,
                                            output crt_result_t res);
    longint unsigned sol;
    status_t st;
    res.sol = '0;
    res.st = ST_OK;
    if (m == 0) begin
      if (p_err == ST_OK) p_err = ST_ZERO;
    end else if (p_cnt >= CRT_MAX_CONG) begin
      if (p_err == ST_OK) p_err = ST_MANY;
    end else begin
      p_res[p_cnt] = r;
      p_mod[p_cnt] = m;
      p_cnt++;
      p_prod = p_prod * m;
    end
    if (!l) return 0;
    st = p_err;
    sol = 0;
    if (st == ST_OK) st = solve_system(sol);
    res.sol = (st == ST_OK) ? sol : 64'd0;
    res.st = st;
    p_cnt = 0; p_prod = 1; p_err = ST_OK;
    return 1;
  endfunction

  always @(posedge clk) begin
    crt_result_t e, got;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("crt_solver_unit regression: fail");
      $finish;
    end
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pending_solutions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: sol=%h st=%0d", out_tdata, out_tuser);
        end else begin
          e = pending_solutions.pop_front();
          if (out_tdata !== e.sol || out_tuser !== e.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp sol=%h st=%0d got sol=%h st=%0d",
                       e.sol, e.st, out_tdata, out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (predict_congruence(in_tdata[15:0], in_tdata[31:16], in_tlast, got)) begin
          if (row_chk) begin
            got.sol = row_sol;
            got.st = row_st;
          end
          pending_solutions.push_back(got);
        end
      end
    end
  end

  // receiver side ready, with optional long hold-off
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic send_congruence(logic [15:0] r, logic [15:0] m, bit l);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {m, r};
    in_tlast <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_modulus();
    int k;
    k = $urandom_range(99);
    if (k < 50) return 16'($urandom_range(65535, 1));
    if (k < 80) return 16'($urandom_range(300, 1));
    return 16'($urandom_range(65535, 65000));
  endfunction

  function automatic longint unsigned gcd16(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b; a = b; b = t;
    end
    return a;
  endfunction

  task automatic send_random_system();
    int kind, len, zpos, tries;
    logic [15:0] mods[6];
    bit ok;
    kind = $urandom_range(99);
    len = (kind >= 88 && kind < 95) ? $urandom_range(6, 5) : $urandom_range(4, 1);
    for (int i = 0; i < len; i++) begin
      tries = 0;
      do begin
        mods[i] = pick_modulus();
        ok = 1;
        for (int j = 0; j < i; j++) if (gcd16(mods[i], mods[j]) != 1) ok = 0;
        tries++;
      end while (kind < 70 && !ok && tries < 30);
    end
    zpos = (kind >= 80 && kind < 88) ? $urandom_range(len - 1) : -1;
    for (int i = 0; i < len; i++)
      send_congruence(16'($urandom_range(65535)), (i == zpos) ? 16'd0 : mods[i],
                      i == len - 1);
  endtask

  dir_row_t dir_tab[22] = '{
    '{16'd0,      16'd1,      1, 1, 64'd0, ST_OK},
    '{16'hffff,   16'hffff,   1, 1, 64'd0, ST_OK},
    '{16'd5,      16'd0,      1, 1, 64'd0, ST_ZERO},
    '{16'd3,      16'd5,      0, 0, 64'd0, ST_OK},
    '{16'd2,      16'd7,      1, 0, 64'd0, ST_OK},
    '{16'd1,      16'd6,      0, 0, 64'd0, ST_OK},
    '{16'd1,      16'd4,      1, 1, 64'd0, ST_COPRIME},
    '{16'd1,      16'd3,      0, 0, 64'd0, ST_OK},
    '{16'd2,      16'd5,      0, 0, 64'd0, ST_OK},
    '{16'd3,      16'd7,      0, 0, 64'd0, ST_OK},
    '{16'd4,      16'd11,     0, 0, 64'd0, ST_OK},
    '{16'd5,      16'd13,     1, 1, 64'd0, ST_MANY},
    '{16'd9,      16'd0,      0, 0, 64'd0, ST_OK},
    '{16'd1,      16'd3,      0, 0, 64'd0, ST_OK},
    '{16'd2,      16'd5,      0, 0, 64'd0, ST_OK},
    '{16'd3,      16'd7,      0, 0, 64'd0, ST_OK},
    '{16'd4,      16'd11,     1, 1, 64'd0, ST_ZERO},
    '{16'd100,    16'd7,      1, 0, 64'd0, ST_OK},
    '{16'hffff,   16'hffff,   0, 0, 64'd0, ST_OK},
    '{16'd0,      16'hfffe,   0, 0, 64'd0, ST_OK},
    '{16'h1234,   16'hfffd,   0, 0, 64'd0, ST_OK},
    '{16'hffff,   16'hfff1,   1, 0, 64'd0, ST_OK}
  };

  initial begin
    int target;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tx_idle = 14; rx_idle = 62;
    foreach (dir_tab[i]) begin
      row_chk = dir_tab[i].chk;
      row_sol = dir_tab[i].s;
      row_st = dir_tab[i].st;
      send_congruence(dir_tab[i].r, dir_tab[i].m, dir_tab[i].l);
    end
    row_chk = 0;

    // long receiver hold-off: the job queue fills and in_tready drops
    hold_cnt = HOLD_CYCLES;
    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin
        tx_idle = 62; rx_idle = 14;
      end else if (p == 2) begin
        tx_idle = 0; rx_idle = 0;
      end
      target = items_sent + 260;
      while (items_sent < target) send_random_system();
      in_tvalid <= 1'b0;
      @(negedge clk);
      wait (pending_solutions.size() == 0);
      @(negedge clk);
    end

    in_tvalid <= 1'b0;
    wait (pending_solutions.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d congruences, checked %0d system results, %0d mismatches",
             items_sent, results_seen, mismatches);
    if (mismatches == 0 && pending_solutions.size() == 0)
      $display("crt_solver_unit regression: pass");
    else
      $display("crt_solver_unit regression: fail");
    $finish;
  end
endmodule
